>>> sv/clts_pkg.sv
// ----------------------------------------------------------------------------
// clts_pkg
// Shared types, constants and the control store of the scrolling LCD front end.
// ----------------------------------------------------------------------------
`default_nettype none

package clts_pkg;

    // Field widths of the two channels.
    localparam int MODE_W    = 3;
    localparam int PAYLOAD_W = 16;
    localparam int BYTE_W    = 8;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_CHAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NUM   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd6;

    // LCD command and character bytes.
    localparam logic [BYTE_W-1:0] CMD_CLEAR   = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_HOME    = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_ENTRY   = 8'h06;
    localparam logic [BYTE_W-1:0] CMD_DISPLAY = 8'h0F;
    localparam logic [BYTE_W-1:0] CMD_FUNC    = 8'h38;
    localparam logic [BYTE_W-1:0] CMD_LINE1   = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_LINE2   = 8'hC0;
    localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;

    // Line numbers for line select.
    localparam logic [BYTE_W-1:0] LINE_ONE = 8'd1;
    localparam logic [BYTE_W-1:0] LINE_TWO = 8'd2;

    // Binary to BCD conversion: 16 input bits, five digits.
    localparam int BCD_W   = 20;
    localparam int CONV_W  = BCD_W + PAYLOAD_W;
    localparam int DAB_W   = 4;
    localparam int DIGIT_W = 3;
    localparam logic [DAB_W-1:0]   DAB_LAST   = 4'd15;
    localparam logic [DIGIT_W-1:0] DIGIT_LAST = 3'd4;

    // Byte source of a bus write.
    localparam logic [2:0] SRC_CONST = 3'd0;
    localparam logic [2:0] SRC_LOW   = 3'd1;
    localparam logic [2:0] SRC_CHAR  = 3'd2;
    localparam logic [2:0] SRC_RAM   = 3'd3;
    localparam logic [2:0] SRC_ADDR  = 3'd4;

    // Jump conditions.
    localparam logic [3:0] C_NEVER   = 4'd0;
    localparam logic [3:0] C_ALWAYS  = 4'd1;
    localparam logic [3:0] C_NOWRAP  = 4'd2;
    localparam logic [3:0] C_ROW0    = 4'd3;
    localparam logic [3:0] C_KMORE   = 4'd4;
    localparam logic [3:0] C_MOREDIG = 4'd5;
    localparam logic [3:0] C_DABMORE = 4'd6;
    localparam logic [3:0] C_LO1     = 4'd7;
    localparam logic [3:0] C_LO2     = 4'd8;
    localparam logic [3:0] C_COL0    = 4'd9;

    // Datapath actions.
    localparam logic [3:0] ACT_NONE    = 4'd0;
    localparam logic [3:0] ACT_WRAP2   = 4'd1;
    localparam logic [3:0] ACT_RW      = 4'd2;
    localparam logic [3:0] ACT_WRAP1   = 4'd3;
    localparam logic [3:0] ACT_PUT     = 4'd4;
    localparam logic [3:0] ACT_NUMNEXT = 4'd5;
    localparam logic [3:0] ACT_NUMLD   = 4'd6;
    localparam logic [3:0] ACT_DAB     = 4'd7;
    localparam logic [3:0] ACT_LDDIG   = 4'd8;
    localparam logic [3:0] ACT_DELPREP = 4'd9;
    localparam logic [3:0] ACT_DELPUT  = 4'd10;
    localparam logic [3:0] ACT_HOME    = 4'd11;

    // Program addresses.
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_NOP     = 5'd0;
    localparam logic [PC_W-1:0] PC_CHR     = 5'd1;
    localparam logic [PC_W-1:0] PC_WRAPCHK = 5'd2;
    localparam logic [PC_W-1:0] PC_CLR2    = 5'd3;
    localparam logic [PC_W-1:0] PC_HOME2   = 5'd4;
    localparam logic [PC_W-1:0] PC_RW      = 5'd5;
    localparam logic [PC_W-1:0] PC_W0      = 5'd6;
    localparam logic [PC_W-1:0] PC_PUT     = 5'd7;
    localparam logic [PC_W-1:0] PC_NUMNEXT = 5'd8;
    localparam logic [PC_W-1:0] PC_NUM     = 5'd9;
    localparam logic [PC_W-1:0] PC_DAB     = 5'd10;
    localparam logic [PC_W-1:0] PC_NUMSEL  = 5'd11;
    localparam logic [PC_W-1:0] PC_RAW     = 5'd12;
    localparam logic [PC_W-1:0] PC_LS      = 5'd13;
    localparam logic [PC_W-1:0] PC_LS_CHK2 = 5'd14;
    localparam logic [PC_W-1:0] PC_LS_1    = 5'd15;
    localparam logic [PC_W-1:0] PC_LS_2    = 5'd16;
    localparam logic [PC_W-1:0] PC_DEL     = 5'd17;
    localparam logic [PC_W-1:0] PC_DEL_DEC = 5'd18;
    localparam logic [PC_W-1:0] PC_DEL_A1  = 5'd19;
    localparam logic [PC_W-1:0] PC_DEL_SP  = 5'd20;
    localparam logic [PC_W-1:0] PC_DEL_A2  = 5'd21;
    localparam logic [PC_W-1:0] PC_CLR     = 5'd22;
    localparam logic [PC_W-1:0] PC_INIT0   = 5'd23;
    localparam logic [PC_W-1:0] PC_INIT1   = 5'd24;
    localparam logic [PC_W-1:0] PC_INIT2   = 5'd25;
    localparam logic [PC_W-1:0] PC_INIT3   = 5'd26;
    localparam logic [PC_W-1:0] PC_INIT4   = 5'd27;
    localparam logic [PC_W-1:0] PC_INIT5   = 5'd28;

    // One control word.
    typedef struct packed {
        logic              emit;
        logic              is_data;
        logic [2:0]        src;
        logic [BYTE_W-1:0] cbyte;
        logic [3:0]        cond;
        logic [PC_W-1:0]   target;
        logic              fin;
        logic [3:0]        act;
    } ucw_t;

    // Builds a control word from its fields.
    function automatic ucw_t ucw(input logic emit, input logic is_data,
                                 input logic [2:0] src, input logic [BYTE_W-1:0] cbyte,
                                 input logic [3:0] cond, input logic [PC_W-1:0] target,
                                 input logic fin, input logic [3:0] act);
        ucw_t w;
        w.emit    = emit;
        w.is_data = is_data;
        w.src     = src;
        w.cbyte   = cbyte;
        w.cond    = cond;
        w.target  = target;
        w.fin     = fin;
        w.act     = act;
        return w;
    endfunction

    // Control store. A taken jump wins over the finish flag.
    function automatic ucw_t clts_ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        unique case (pc)
            PC_CHR:     w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_NOWRAP, PC_PUT, 1'b0, ACT_NONE);
            PC_WRAPCHK: w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_ROW0, PC_W0, 1'b0, ACT_NONE);
            PC_CLR2:    w = ucw(1'b1, 1'b0, SRC_CONST, CMD_CLEAR, C_NEVER, PC_NOP, 1'b0,
                                ACT_WRAP2);
            PC_HOME2:   w = ucw(1'b1, 1'b0, SRC_CONST, CMD_LINE1, C_NEVER, PC_NOP, 1'b0,
                                ACT_NONE);
            PC_RW:      w = ucw(1'b1, 1'b1, SRC_RAM, 8'h00, C_KMORE, PC_RW, 1'b0, ACT_RW);
            PC_W0:      w = ucw(1'b1, 1'b0, SRC_CONST, CMD_LINE2, C_NEVER, PC_NOP, 1'b0,
                                ACT_WRAP1);
            PC_PUT:     w = ucw(1'b1, 1'b1, SRC_CHAR, 8'h00, C_MOREDIG, PC_NUMNEXT, 1'b1,
                                ACT_PUT);
            PC_NUMNEXT: w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_ALWAYS, PC_CHR, 1'b0,
                                ACT_NUMNEXT);
            PC_NUM:     w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_NEVER, PC_NOP, 1'b0,
                                ACT_NUMLD);
            PC_DAB:     w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_DABMORE, PC_DAB, 1'b0,
                                ACT_DAB);
            PC_NUMSEL:  w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_ALWAYS, PC_CHR, 1'b0,
                                ACT_LDDIG);
            PC_RAW:     w = ucw(1'b1, 1'b0, SRC_LOW, 8'h00, C_NEVER, PC_NOP, 1'b1, ACT_NONE);
            PC_LS:      w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_LO1, PC_LS_1, 1'b0, ACT_NONE);
            PC_LS_CHK2: w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_LO2, PC_LS_2, 1'b1, ACT_NONE);
            PC_LS_1:    w = ucw(1'b1, 1'b0, SRC_CONST, CMD_LINE1, C_NEVER, PC_NOP, 1'b1,
                                ACT_NONE);
            PC_LS_2:    w = ucw(1'b1, 1'b0, SRC_CONST, CMD_LINE2, C_NEVER, PC_NOP, 1'b1,
                                ACT_NONE);
            PC_DEL:     w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_COL0, PC_NOP, 1'b0, ACT_NONE);
            PC_DEL_DEC: w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_NEVER, PC_NOP, 1'b0,
                                ACT_DELPREP);
            PC_DEL_A1:  w = ucw(1'b1, 1'b0, SRC_ADDR, 8'h00, C_NEVER, PC_NOP, 1'b0, ACT_NONE);
            PC_DEL_SP:  w = ucw(1'b1, 1'b1, SRC_CHAR, 8'h00, C_NEVER, PC_NOP, 1'b0,
                                ACT_DELPUT);
            PC_DEL_A2:  w = ucw(1'b1, 1'b0, SRC_ADDR, 8'h00, C_NEVER, PC_NOP, 1'b1, ACT_NONE);
            PC_CLR:     w = ucw(1'b1, 1'b0, SRC_CONST, CMD_CLEAR, C_NEVER, PC_NOP, 1'b1,
                                ACT_NONE);
            PC_INIT0:   w = ucw(1'b1, 1'b0, SRC_CONST, CMD_FUNC, C_NEVER, PC_NOP, 1'b0,
                                ACT_NONE);
            PC_INIT1:   w = ucw(1'b1, 1'b0, SRC_CONST, CMD_ENTRY, C_NEVER, PC_NOP, 1'b0,
                                ACT_NONE);
            PC_INIT2:   w = ucw(1'b1, 1'b0, SRC_CONST, CMD_DISPLAY, C_NEVER, PC_NOP, 1'b0,
                                ACT_NONE);
            PC_INIT3:   w = ucw(1'b1, 1'b0, SRC_CONST, CMD_HOME, C_NEVER, PC_NOP, 1'b0,
                                ACT_NONE);
            PC_INIT4:   w = ucw(1'b1, 1'b0, SRC_CONST, CMD_CLEAR, C_NEVER, PC_NOP, 1'b0,
                                ACT_NONE);
            PC_INIT5:   w = ucw(1'b1, 1'b0, SRC_CONST, CMD_LINE1, C_NEVER, PC_NOP, 1'b1,
                                ACT_HOME);
            default:    w = ucw(1'b0, 1'b0, SRC_CONST, 8'h00, C_NEVER, PC_NOP, 1'b1, ACT_NONE);
        endcase
        return w;
    endfunction

    // First program step of each mode.
    function automatic logic [PC_W-1:0] clts_entry(input logic [MODE_W-1:0] mode);
        logic [PC_W-1:0] pc;
        unique case (mode)
            MODE_CHAR:  pc = PC_CHR;
            MODE_RAW:   pc = PC_RAW;
            MODE_LINE:  pc = PC_LS;
            MODE_DEL:   pc = PC_DEL;
            MODE_CLEAR: pc = PC_CLR;
            MODE_NUM:   pc = PC_NUM;
            MODE_INIT:  pc = PC_INIT0;
            default:    pc = PC_NOP;
        endcase
        return pc;
    endfunction

    // One shift-and-add-three step of the binary to BCD conversion.
    function automatic logic [CONV_W-1:0] clts_dabble(input logic [CONV_W-1:0] s);
        logic [CONV_W-1:0] t;
        t = s;
        for (int i = 0; i < BCD_W / 4; i++) begin
            if (t[PAYLOAD_W + 4*i +: 4] >= 4'd5)
            begin
                t[PAYLOAD_W + 4*i +: 4] = t[PAYLOAD_W + 4*i +: 4] + 4'd3;
            end
        end
        return {t[CONV_W-2:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

>>> sv/clts_req_if.sv
// ----------------------------------------------------------------------------
// clts_req_if
// Request channel: one item is one terminal request (mode and payload).
// ----------------------------------------------------------------------------
`default_nettype none

interface clts_req_if import clts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output mode, output payload, input ready);
    modport sink   (input valid, input mode, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/clts_wr_if.sv
// ----------------------------------------------------------------------------
// clts_wr_if
// LCD write channel: one item is one bus write, command or data.
// ----------------------------------------------------------------------------
`default_nettype none

interface clts_wr_if import clts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              is_data;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;

    modport source (output valid, output is_data, output bus_byte, output last,
                    input ready);
    modport sink   (input valid, input is_data, input bus_byte, input last,
                    output ready);
endinterface

`default_nettype wire

>>> sv/clts_ram.sv
// ----------------------------------------------------------------------------
// clts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/char_lcd_scrolling_terminal_top.sv
// ----------------------------------------------------------------------------
// char_lcd_scrolling_terminal_top
// Two-line character LCD terminal front end with scrolling of line two.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (mode, payload); each request becomes zero or
// more LCD bus writes on wr, in bus order, with last set on the final write
// of the request. A request that causes no write yields no item on wr.
// A small sequencer walks a control store, one step per cycle, and emits at
// most one write per step into an output register.
// A delete is ignored at column zero. A character past the last column first
// moves to line two, or, when already there, scrolls line two up to line one:
// the stored line is replayed from the line RAM, one entry per cycle while wr
// does not stall. A decimal number is converted from binary to BCD first, then
// its five digits are printed like characters, most significant first. Each
// write is loaded into the output register by its step and drives wr from there.
// req.ready is high whenever no request is in progress; a new request may be
// taken while the last write of the previous one still waits on wr.
// If wr stalls, the sequencer holds on its next write step until the output
// register frees up. Reset clears cursor column and row and idles the
// sequencer; the stored copy of line two is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_scrolling_terminal_top import clts_pkg::*; #(
    parameter int NUM_COLUMNS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    clts_req_if.sink req,
    clts_wr_if.source wr
);

    localparam int COL_W  = $clog2(NUM_COLUMNS + 1);
    localparam int ADDR_W = $clog2(NUM_COLUMNS);
    localparam logic [COL_W-1:0]  COL_END = COL_W'(NUM_COLUMNS);
    localparam logic [ADDR_W-1:0] K_LAST  = ADDR_W'(NUM_COLUMNS - 1);

    // Control state.
    logic              busy_reg, busy_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              row_reg, row_next;
    logic              out_valid_reg, out_valid_next;

    // Working registers of the current request.
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;
    logic [BYTE_W-1:0]    ch_reg, ch_next;
    logic                 num_reg, num_next;
    logic [ADDR_W-1:0]    k_reg, k_next;
    logic [CONV_W-1:0]    conv_reg, conv_next;
    logic [DAB_W-1:0]     dab_reg, dab_next;
    logic [DIGIT_W-1:0]   dig_reg, dig_next;
    logic                 is_data_reg, is_data_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 last_reg, last_next;

    ucw_t              cw;
    logic              accept;
    logic              go;
    logic              cond_ok;
    logic              taken;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] wr_byte;

    // Current control word and step handshake.
    assign cw     = clts_ucode(pc_reg);
    assign accept = req.valid && !busy_reg;
    assign go     = busy_reg && (!cw.emit || !out_valid_reg || wr.ready);
    assign taken  = go && cond_ok;

    assign req.ready   = !busy_reg;
    assign wr.valid    = out_valid_reg;
    assign wr.is_data  = is_data_reg;
    assign wr.bus_byte = byte_reg;
    assign wr.last     = last_reg;

    // Jump condition evaluation.
    always_comb
    begin
        unique case (cw.cond)
            C_ALWAYS:  cond_ok = 1'b1;
            C_NOWRAP:  cond_ok = col_reg < COL_END;
            C_ROW0:    cond_ok = !row_reg;
            C_KMORE:   cond_ok = k_reg != K_LAST;
            C_MOREDIG: cond_ok = num_reg && (dig_reg != DIGIT_LAST);
            C_DABMORE: cond_ok = dab_reg != DAB_LAST;
            C_LO1:     cond_ok = pay_reg[BYTE_W-1:0] == LINE_ONE;
            C_LO2:     cond_ok = pay_reg[BYTE_W-1:0] == LINE_TWO;
            C_COL0:    cond_ok = col_reg == '0;
            default:   cond_ok = 1'b0;
        endcase
    end

    // Byte selection for the write of this step.
    always_comb
    begin
        unique case (cw.src)
            SRC_LOW:  wr_byte = pay_reg[BYTE_W-1:0];
            SRC_CHAR: wr_byte = ch_reg;
            SRC_RAM:  wr_byte = ram_rdata;
            SRC_ADDR: wr_byte = (row_reg ? CMD_LINE2 : CMD_LINE1) + BYTE_W'(col_reg);
            default:  wr_byte = cw.cbyte;
        endcase
    end

    // Line two copy is written by character puts on line two.
    assign ram_we = go && ((cw.act == ACT_PUT) || (cw.act == ACT_DELPUT))
                    && row_reg && (col_reg < COL_END);

    // Sequencer and datapath next state.
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        pay_next       = pay_reg;
        ch_next        = ch_reg;
        num_next       = num_reg;
        k_next         = k_reg;
        conv_next      = conv_reg;
        dab_next       = dab_reg;
        dig_next       = dig_reg;
        is_data_next   = is_data_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        // Output register: load on an emitting step, drain when taken.
        if (go && cw.emit)
        begin
            out_valid_next = 1'b1;
            is_data_next   = cw.is_data;
            byte_next      = wr_byte;
            last_next      = cw.fin && !cond_ok;
        end
        else if (wr.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Dispatch a new request.
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = clts_entry(req.mode);
            pay_next  = req.payload;
            ch_next   = req.payload[BYTE_W-1:0];
            num_next  = req.mode == MODE_NUM;
        end

        // Step sequencing.
        if (go)
        begin
            if (taken)
            begin
                pc_next = cw.target;
            end
            else if (cw.fin)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end

            unique case (cw.act)
                ACT_WRAP2:
                begin
                    row_next = 1'b0;
                    col_next = '0;
                    k_next   = '0;
                end
                ACT_RW:
                begin
                    col_next = col_reg + 1'b1;
                    if (k_reg != K_LAST)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                ACT_WRAP1:
                begin
                    row_next = 1'b1;
                    col_next = '0;
                end
                ACT_PUT:
                begin
                    col_next = col_reg + 1'b1;
                end
                ACT_NUMNEXT:
                begin
                    conv_next = conv_reg << 4;
                    ch_next   = CHAR_ZERO + BYTE_W'(conv_reg[CONV_W-5 -: 4]);
                    dig_next  = dig_reg + 1'b1;
                end
                ACT_NUMLD:
                begin
                    conv_next = {{BCD_W{1'b0}}, pay_reg};
                    dab_next  = '0;
                    dig_next  = '0;
                end
                ACT_DAB:
                begin
                    conv_next = clts_dabble(conv_reg);
                    dab_next  = dab_reg + 1'b1;
                end
                ACT_LDDIG:
                begin
                    ch_next = CHAR_ZERO + BYTE_W'(conv_reg[CONV_W-1 -: 4]);
                end
                ACT_DELPREP:
                begin
                    col_next = col_reg - 1'b1;
                    ch_next  = CHAR_SPACE;
                end
                ACT_HOME:
                begin
                    col_next = '0;
                    row_next = 1'b0;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= PC_NOP;
            col_reg       <= '0;
            row_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        pay_reg     <= pay_next;
        ch_reg      <= ch_next;
        num_reg     <= num_next;
        k_reg       <= k_next;
        conv_reg    <= conv_next;
        dab_reg     <= dab_next;
        dig_reg     <= dig_next;
        is_data_reg <= is_data_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

    // Copy of line two; it is read at k_next so that the registered read data holds the entry for k_reg.
    clts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (NUM_COLUMNS)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg[ADDR_W-1:0]),
        .wdata (ch_reg),
        .raddr (k_next),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

>>> tb/sv/lcd_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_write_checker
// Watches the request and LCD write channels of the terminal front end. Every
// accepted request is run through a behavioral copy of the cursor and the
// stored second line, and the bus writes it should cause are queued. Every
// accepted write is compared field by field with the oldest queued write.
// ----------------------------------------------------------------------------
module lcd_write_checker import clts_pkg::*; #(
    parameter int NUM_COLUMNS = 16
) (
    input  logic clk,
    input  logic rst_n,
    clts_req_if  req,
    clts_wr_if   wr,
    output int   pending,
    output int   errors
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic              is_data;
        logic [BYTE_W-1:0] bus_byte;
        logic              last;
    } lcd_write_t;

    // Writes still owed by the block, oldest first.
    lcd_write_t        exp_writes[$];
    int                cur_col;
    logic              cur_row;
    logic [BYTE_W-1:0] line_two [NUM_COLUMNS];
    int                writes_seen;

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS)
        begin
            $display("[%0t] lcd write %0d: %s", $time, writes_seen, what);
        end
        errors++;
    endtask

    task automatic queue_write(input logic is_data, input logic [BYTE_W-1:0] value);
        lcd_write_t w;
        w.is_data  = is_data;
        w.bus_byte = value;
        w.last     = 1'b0;
        exp_writes.push_back(w);
    endtask

    // Data write at the cursor; characters on line two are kept for scrolling.
    task automatic write_glyph(input logic [BYTE_W-1:0] ch);
        queue_write(1'b1, ch);
        if (cur_row && cur_col < NUM_COLUMNS)
        begin
            line_two[cur_col] = ch;
        end
        if (cur_col <= NUM_COLUMNS)
        begin
            cur_col++;
        end
    endtask

    // A character past the last column first moves to line two, or scrolls
    // line two up to line one when already there.
    task automatic print_char(input logic [BYTE_W-1:0] ch);
        if (cur_col >= NUM_COLUMNS)
        begin
            if (cur_row)
            begin
                cur_row = 1'b0;
                cur_col = 0;
                queue_write(1'b0, CMD_CLEAR);
                queue_write(1'b0, CMD_LINE1);
                for (int k = 0; k < NUM_COLUMNS; k++)
                begin
                    write_glyph(line_two[k]);
                end
            end
            cur_row = 1'b1;
            cur_col = 0;
            queue_write(1'b0, CMD_LINE2);
        end
        write_glyph(ch);
    endtask

    // Queues the bus writes one request causes and updates the cursor state.
    task automatic predict_request(input logic [MODE_W-1:0] mode,
                                   input logic [PAYLOAD_W-1:0] value);
        int                first;
        int                divisor;
        int                digit;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] addr;
        lcd_write_t        tail;
        first = exp_writes.size();
        lo    = value[BYTE_W-1:0];
        case (mode)
            MODE_CHAR:
                print_char(lo);
            MODE_RAW:
                queue_write(1'b0, lo);
            MODE_LINE:
            begin
                if (lo == LINE_ONE)
                begin
                    queue_write(1'b0, CMD_LINE1);
                end
                else if (lo == LINE_TWO)
                begin
                    queue_write(1'b0, CMD_LINE2);
                end
            end
            MODE_DEL:
            begin
                // Ignored at column zero; otherwise a space overwrites the
                // previous column and the cursor ends one column back.
                if (cur_col != 0)
                begin
                    cur_col--;
                    addr = (cur_row ? CMD_LINE2 : CMD_LINE1) + cur_col[BYTE_W-1:0];
                    queue_write(1'b0, addr);
                    print_char(CHAR_SPACE);
                    if (cur_col > 0)
                    begin
                        cur_col--;
                    end
                    queue_write(1'b0, addr);
                end
            end
            MODE_CLEAR:
                queue_write(1'b0, CMD_CLEAR);
            MODE_NUM:
            begin
                // Five decimal digits, most significant first.
                divisor = 10000;
                repeat (5)
                begin
                    digit = (int'(value) / divisor) % 10;
                    print_char(CHAR_ZERO + digit[BYTE_W-1:0]);
                    divisor = divisor / 10;
                end
            end
            MODE_INIT:
            begin
                queue_write(1'b0, CMD_FUNC);
                queue_write(1'b0, CMD_ENTRY);
                queue_write(1'b0, CMD_DISPLAY);
                queue_write(1'b0, CMD_HOME);
                queue_write(1'b0, CMD_CLEAR);
                queue_write(1'b0, CMD_LINE1);
                cur_col = 0;
                cur_row = 1'b0;
            end
            default:
                ;
        endcase
        // Mark the final write of this request.
        if (exp_writes.size() > first)
        begin
            tail      = exp_writes.pop_back();
            tail.last = 1'b1;
            exp_writes.push_back(tail);
        end
    endtask

    task automatic check_write(input logic is_data, input logic [BYTE_W-1:0] value,
                               input logic last);
        lcd_write_t want;
        if (exp_writes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected write is_data=%0b bus_byte=0x%02h last=%0b",
                                      is_data, value, last));
        end
        else
        begin
            want = exp_writes.pop_front();
            if (is_data !== want.is_data)
            begin
                report_mismatch($sformatf("is_data got %0b expected %0b",
                                          is_data, want.is_data));
            end
            if (value !== want.bus_byte)
            begin
                report_mismatch($sformatf("bus_byte got 0x%02h expected 0x%02h",
                                          value, want.bus_byte));
            end
            if (last !== want.last)
            begin
                report_mismatch($sformatf("last got %0b expected %0b", last, want.last));
            end
        end
        writes_seen++;
    endtask

    // Both channels are sampled at the rising edge, before the block updates.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col     = 0;
            cur_row     = 1'b0;
            writes_seen = 0;
            errors      = 0;
            exp_writes.delete();
            foreach (line_two[k])
            begin
                line_two[k] = '0;
            end
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_request(req.mode, req.payload);
            end
            if (wr.valid && wr.ready)
            begin
                check_write(wr.is_data, wr.bus_byte, wr.last);
            end
        end
        pending = exp_writes.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the scrolling LCD terminal front end with a directed sequence that
// walks line wrap, scrolling and every request mode, then with random
// requests, at first under random source gaps and write-side stalls. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import clts_pkg::*; ();

    localparam int NUM_COLUMNS     = 16;
    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_REQUESTS = 405;
    localparam int QUIET_REQUESTS  = 60;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 1000000;

    // Mode code that the block does not define.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   pending;
    int   errors;
    int   cycle_count = 0;

    clts_req_if req ();
    clts_wr_if  wr ();

    char_lcd_scrolling_terminal_top #(
        .NUM_COLUMNS(NUM_COLUMNS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .wr    (wr)
    );

    lcd_write_checker #(
        .NUM_COLUMNS(NUM_COLUMNS)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .wr      (wr),
        .pending (pending),
        .errors  (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Presents one request and holds it until the block takes it.
    task automatic send_req(input logic [MODE_W-1:0] mode, input logic [PAYLOAD_W-1:0] value);
        @(negedge clk);
        req.valid   <= 1'b1;
        req.mode    <= mode;
        req.payload <= value;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
    endtask

    task automatic pause_req(input int cycles);
        @(negedge clk);
        req.valid   <= 1'b0;
        req.payload <= PAYLOAD_W'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Holds the source off until every predicted write has come out.
    task automatic wait_for_drain();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Mostly characters and numbers so that wrap and scroll are reached often.
    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return MODE_CHAR;
        else if (r < 63)
            return MODE_NUM;
        else if (r < 75)
            return MODE_DEL;
        else if (r < 81)
            return MODE_RAW;
        else if (r < 87)
            return MODE_LINE;
        else if (r < 92)
            return MODE_CLEAR;
        else if (r < 95)
            return MODE_INIT;
        else
            return MODE_UNUSED;
    endfunction

    // Write side: runs of readiness, some long, broken by stall bursts; always ready when quiet.
    initial
    begin
        int n;
        wr.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                wr.ready <= 1'b1;
            end
            else
            begin
                wr.ready <= 1'b1;
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
                repeat (n - 1) @(negedge clk);
                @(negedge clk);
                wr.ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [MODE_W-1:0]    mode;
        logic [PAYLOAD_W-1:0] value;
        bit                   choppy;
        rst_n       = 1'b0;
        quiet       = 1'b0;
        req.valid   = 1'b0;
        req.mode    = MODE_CHAR;
        req.payload = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Every mode, ignored cases, both wraps and a scroll at the start of a number.
        send_req(MODE_INIT, 16'h0000);
        send_req(MODE_RAW, 16'h0000);
        send_req(MODE_RAW, 16'hFFFF);
        send_req(MODE_LINE, {8'h00, LINE_ONE});
        send_req(MODE_LINE, {8'hFF, LINE_TWO});
        send_req(MODE_LINE, 16'h0000);
        send_req(MODE_LINE, 16'h0003);
        send_req(MODE_CLEAR, 16'hFFFF);
        send_req(MODE_UNUSED, 16'hFFFF);
        send_req(MODE_DEL, 16'h0000);
        send_req(MODE_NUM, 16'd65535);
        send_req(MODE_NUM, 16'd0);
        send_req(MODE_NUM, 16'd12345);
        send_req(MODE_CHAR, 16'h0000);
        send_req(MODE_DEL, 16'hFFFF);
        send_req(MODE_CHAR, 16'h00FF);
        send_req(MODE_CHAR, 16'hFF7E);
        send_req(MODE_DEL, 16'h0000);
        send_req(MODE_DEL, 16'h0000);
        send_req(MODE_NUM, 16'd40000);
        send_req(MODE_NUM, 16'd9);
        send_req(MODE_NUM, 16'd31415);
        send_req(MODE_CHAR, 16'h0080);
        send_req(MODE_NUM, 16'd54321);
        wait_for_drain();

        // Random requests; source gaps come in alternating stretches.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 2)
            begin
                wait_for_drain();
            end
            quiet  = (i >= RANDOM_REQUESTS - QUIET_REQUESTS);
            choppy = ((i / 50) % 2 == 0);
            if (!quiet && choppy && $urandom_range(0, 3) == 0)
            begin
                pause_req($urandom_range(1, 19));
            end
            mode  = pick_mode();
            value = PAYLOAD_W'($urandom_range(0, 16'hFFFF));
            if (mode == MODE_LINE && $urandom_range(0, 1) == 1)
            begin
                value[BYTE_W-1:0] = ($urandom_range(0, 1) == 1) ? LINE_ONE : LINE_TWO;
            end
            send_req(mode, value);
        end
        @(negedge clk);
        req.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/clts_pkg.sv
sv/clts_req_if.sv
sv/clts_wr_if.sv
sv/clts_ram.sv
sv/char_lcd_scrolling_terminal_top.sv
tb/sv/lcd_write_checker.sv
tb/sv/tb_top.sv
